[design/aml_sleep_type_scanner_assert.svh]
// Assertion macros shared by the checker of the sleep type scanner.
// Every macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef AML_SLEEP_TYPE_SCANNER_ASSERT_SVH
`define AML_SLEEP_TYPE_SCANNER_ASSERT_SVH

// Property checked on every rising edge outside of reset.
`define ASTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define ASTS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/asts_pkg.sv]
// Shared types and constants of the sleep type scanner.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
`default_nettype none

package asts_pkg;

   // Default upper bound of the table length given in the header.
   localparam int MAX_TABLE_BYTES_DEF = 262144;

   // Header checks and scan limits.
   localparam int HDR_MIN_LEN = 44;
   localparam int SCAN_START  = 36;
   // A start position is tested when the byte this many places after it arrives.
   localparam int PROBE_LAG   = 13;

   // Result codes.
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_BAD_SIG   = 3'd1;
   localparam logic [2:0] ST_BAD_LEN   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_TRUNC     = 3'd4;

   // Table signature and AML byte codes.
   localparam logic [7:0] SIG_CHAR_D  = 8'h44;
   localparam logic [7:0] SIG_CHAR_S  = 8'h53;
   localparam logic [7:0] SIG_CHAR_T  = 8'h54;
   localparam logic [7:0] NAME_OP     = 8'h08;
   localparam logic [7:0] ROOT_CHAR   = 8'h5C;
   localparam logic [7:0] UNDERSCORE  = 8'h5F;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] PACKAGE_OP  = 8'h12;
   localparam logic [7:0] BYTE_PREFIX = 8'h0A;

   // Reset value of the sleep digit register, ASCII '5'.
   localparam logic [5:0] DIGIT_RESET = 6'd53;

   // Offset of the first package value behind the name, before the PkgLength follow bytes.
   localparam logic [3:0] PKG_BASE_OFF = 4'd7;
   // The probe view starts two bytes ahead of the start position.
   localparam logic [3:0] VIEW_BIAS    = 4'd2;

   // Number of in-bounds offsets seen by a probe: all of them, and the end-of-table sweep.
   localparam logic [3:0] AVAIL_ALL   = 4'd14;
   localparam logic [3:0] FLUSH_FIRST = 4'd13;
   localparam logic [3:0] FLUSH_LAST  = 4'd9;

   // Expected signature byte for header offsets zero to three.
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = SIG_CHAR_D;
         2'd1: b = SIG_CHAR_S;
         2'd2: b = SIG_CHAR_D;
         default: b = SIG_CHAR_T;
      endcase
      return b;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;        // an item of the current table is taken in
      logic restart;     // the item opens a new table
      logic load_out;    // load the result register
      logic flush_step;  // one step of the end-of-table sweep
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_result;   // the incoming item decides the table
      logic at_end;        // the incoming item is the last one of the table
      logic flush_result;  // the current sweep step decides the table
   } dp_stat_type;

endpackage

`default_nettype wire

[design/asts_dp.sv]
// Datapath of the sleep type scanner: byte window, header registers, pattern probe, result.
// Depends on asts_pkg; driven by asts_ctrl.
`default_nettype none

module asts_dp import asts_pkg::*; #(
   parameter int MAX_TABLE_BYTES = MAX_TABLE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_cmd_type cmd,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        csr_valid,
   input  wire logic [5:0]  csr_sleep_digit,
   output dp_stat_type      stat,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_type_a,
   output logic [2:0]       rsp_type_b
);

   localparam int LEN_W = $clog2(MAX_TABLE_BYTES + 1);
   localparam int SUM_W = 33;
   localparam logic [SUM_W-1:0] MAX_LEN    = SUM_W'(MAX_TABLE_BYTES);
   localparam logic [LEN_W-1:0] MIN_LEN    = LEN_W'(HDR_MIN_LEN);
   localparam logic [LEN_W-1:0] PROBE_FROM = LEN_W'(SCAN_START + PROBE_LAG);
   localparam logic [LEN_W-1:0] SCAN_FLOOR = LEN_W'(SCAN_START);
   localparam logic [LEN_W-1:0] SIG_END    = LEN_W'(4);
   localparam logic [LEN_W-1:0] HDR_END    = LEN_W'(8);

   // Sixteen bytes, newest at the top.
   typedef logic [15:0][7:0] view_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] ta;
      logic [2:0] tb;
   } probe_type;

   // Tests one start position. Entry k of the view holds the byte two places before the
   // position plus k; avail is how many offsets from the position lie inside the table.
   function automatic probe_type probe(input view_type v, input logic [3:0] avail,
                                       input logic [5:0] digit);
      probe_type  r;
      logic [3:0] off;
      logic       ok;
      logic [7:0] a;
      ok = (v[2] == UNDERSCORE) && (v[3] == CHAR_S) && (v[4] == {2'b00, digit}) &&
           (v[5] == UNDERSCORE) && (v[6] == PACKAGE_OP) &&
           ((v[1] == NAME_OP) || ((v[0] == NAME_OP) && (v[1] == ROOT_CHAR)));
      off = PKG_BASE_OFF + {2'b00, v[7][7:6]};
      ok  = ok && (off < avail);
      if (v[off + VIEW_BIAS] == BYTE_PREFIX) begin
         off = off + 4'd1;
      end
      ok  = ok && (off < avail);
      a   = v[off + VIEW_BIAS];
      off = off + 4'd1;
      ok  = ok && (off < avail);
      if (v[off + VIEW_BIAS] == BYTE_PREFIX) begin
         off = off + 4'd1;
      end
      ok    = ok && (off < avail);
      r.hit = ok;
      r.ta  = ok ? a[2:0] : 3'd0;
      r.tb  = ok ? v[off + VIEW_BIAS][2:0] : 3'd0;
      return r;
   endfunction

   view_type         win_ff, win_in, view_next, flush_view;
   logic [LEN_W-1:0] count_ff, len_ff;
   logic             ovf_ff;
   logic [5:0]       digit_ff;
   logic [3:0]       avail_ff;
   logic [2:0]       status_ff, type_a_ff, type_b_ff;

   logic [LEN_W-1:0] pos, len_cur, len_in, count_in;
   logic             ovf_cur, ovf_in;
   logic [SUM_W-1:0] len_sum;
   logic             sum_ovf, hdr_sig, hdr_len, body;
   logic             sig_bad, len_bad, scan_hit, flush_on, flush_hit;
   probe_type        scan_probe, flush_probe;
   logic [2:0]       item_code, out_code, out_ta, out_tb;

   always_comb begin
      pos     = cmd.restart ? '0 : count_ff;
      len_cur = cmd.restart ? '0 : len_ff;
      ovf_cur = cmd.restart ? 1'b0 : ovf_ff;
      hdr_sig = pos < SIG_END;
      hdr_len = !hdr_sig && (pos < HDR_END);
      body    = !hdr_sig && !hdr_len;

      sig_bad = hdr_sig && (req_data_byte != sig_byte(pos[1:0]));

      // Length bytes arrive least significant first.
      len_sum  = SUM_W'(len_cur) + (SUM_W'(req_data_byte) << {pos[1:0], 3'b000});
      sum_ovf  = len_sum > MAX_LEN;
      len_in   = (hdr_len && !ovf_cur && !sum_ovf) ? len_sum[LEN_W-1:0] : len_cur;
      ovf_in   = ovf_cur || (hdr_len && sum_ovf);
      len_bad  = hdr_len && (pos[2:0] == 3'd7) && (ovf_in || (len_in < MIN_LEN));
      count_in = pos + LEN_W'(1);

      view_next  = {req_data_byte, win_ff[15:1]};
      scan_probe = probe(view_next, AVAIL_ALL, digit_ff);
      scan_hit   = body && (pos >= PROBE_FROM) && scan_probe.hit;

      flush_view  = {8'h00, win_ff[15:1]};
      flush_probe = probe(flush_view, avail_ff, digit_ff);
      flush_on    = (LEN_W'(avail_ff) + SCAN_FLOOR) <= len_ff;
      flush_hit   = flush_on && flush_probe.hit;

      stat.item_result  = sig_bad || len_bad || scan_hit;
      stat.at_end       = body && (count_in >= len_cur);
      stat.flush_result = flush_hit || (avail_ff == FLUSH_LAST);

      if (sig_bad) begin
         item_code = ST_BAD_SIG;
      end else if (len_bad) begin
         item_code = ST_BAD_LEN;
      end else if (scan_hit) begin
         item_code = ST_FOUND;
      end else begin
         item_code = ST_TRUNC;
      end

      if (cmd.flush_step) begin
         out_code = flush_hit ? ST_FOUND : ST_NOT_FOUND;
         out_ta   = flush_hit ? flush_probe.ta : 3'd0;
         out_tb   = flush_hit ? flush_probe.tb : 3'd0;
      end else begin
         out_code = item_code;
         out_ta   = scan_hit ? scan_probe.ta : 3'd0;
         out_tb   = scan_hit ? scan_probe.tb : 3'd0;
      end

      if (cmd.take) begin
         win_in = view_next;
      end else if (cmd.flush_step) begin
         win_in = flush_view;
      end else begin
         win_in = win_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         digit_ff <= DIGIT_RESET;
      end else begin
         if (csr_valid) begin
            digit_ff <= csr_sleep_digit;
         end
         if (cmd.take) begin
            count_ff <= count_in;
            len_ff   <= len_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (cmd.take) begin
         avail_ff <= FLUSH_FIRST;
      end else if (cmd.flush_step) begin
         avail_ff <= avail_ff - 4'd1;
      end
      if (cmd.load_out) begin
         status_ff <= out_code;
         type_a_ff <= out_ta;
         type_b_ff <= out_tb;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_type_a = type_a_ff;
   assign rsp_type_b = type_b_ff;

endmodule

`default_nettype wire

[design/asts_ctrl.sv]
// Controller of the sleep type scanner: table state, handshakes and result valid.
// Depends on asts_pkg; commands asts_dp.
`default_nettype none

module asts_ctrl import asts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_first,
   input  wire logic        req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output ctl_cmd_type      cmd
);

   typedef enum logic [1:0] {S_WAIT, S_SCAN, S_FLUSH} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, accept, active;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff != S_FLUSH) && out_free;
      accept    = req_valid && req_ready;
      active    = accept && (req_first || (state_ff == S_SCAN));

      cmd.take       = active;
      cmd.restart    = accept && req_first;
      cmd.flush_step = (state_ff == S_FLUSH) && out_free;
      cmd.load_out   = (active && (stat.item_result || (req_last && !stat.at_end))) ||
                       (cmd.flush_step && stat.flush_result);

      state_in = state_ff;
      case (state_ff)
         S_WAIT, S_SCAN: begin
            if (active) begin
               if (cmd.load_out) begin
                  state_in = S_WAIT;
               end else if (stat.at_end) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_FLUSH: begin
            if (cmd.load_out) begin
               state_in = S_WAIT;
            end
         end
         default: state_in = S_WAIT;
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[design/aml_sleep_type_scanner.sv]
// Top level of the sleep type scanner: controller plus datapath.
// Depends on asts_pkg, asts_ctrl and asts_dp.
//
// Usage:
// The req channel carries one byte of a DSDT table per item, in address order. An item with
// req_first high opens a new table and drops any table still pending, without a result.
// Items without req_first are taken and ignored while no table is open.
// The rsp channel gives one item per table: a status code and the two sleep types of the
// first matching _Sx_ package (zero unless the status is found). The deciding item is the
// failing signature byte, length byte seven, the byte thirteen places after a hit, the last
// table byte, or a byte with req_last high that decides nothing else (truncated).
// The csr channel writes the sleep digit sought; it is always ready. The user must write it
// only while no table is in flight; the block itself does not enforce this.
// Throughput and timing: one item per cycle while req_ready is high. The result is registered
// and shows in the cycle after the deciding item. When the last table byte yields no hit,
// a sweep over the final five start positions follows, one position per cycle through a
// second probe, and req_ready stays low meanwhile.
// Stalls: a result waiting in the output register holds req_ready low until rsp_ready
// rises; a receiver that keeps rsp_ready high slows the input only during the sweep.
// Reset: synchronous; no table is open, the output register is empty and the sleep digit
// returns to ASCII '5'.
`default_nettype none

module aml_sleep_type_scanner import asts_pkg::*; #(
   parameter int MAX_TABLE_BYTES = MAX_TABLE_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_first,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [2:0]      rsp_type_a,
   output logic [2:0]      rsp_type_b,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [5:0] csr_sleep_digit
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // The sleep digit register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // The controller owns the table state and both handshakes.
   asts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_first (req_first),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the byte window, the header fields and the result register.
   asts_dp #(
      .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .csr_valid       (csr_valid),
      .csr_sleep_digit (csr_sleep_digit),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_type_a      (rsp_type_a),
      .rsp_type_b      (rsp_type_b)
   );

endmodule

`default_nettype wire

[design/asts_checker.sv]
// Port-level checker of the sleep type scanner and its bind to the top level.
// Depends on asts_pkg and aml_sleep_type_scanner_assert.svh.
`default_nettype none

`include "aml_sleep_type_scanner_assert.svh"

module asts_checker import asts_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_data_byte,
   input wire logic       req_first,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [2:0] rsp_type_a,
   input wire logic [2:0] rsp_type_b
);

   // A stalled result holds still.
   `ASTS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_type_a) && $stable(rsp_type_b), "stalled result changed")

   // Only a found status carries sleep types.
   `ASTS_ASSERT(a_types_zero, rsp_valid && (rsp_status != ST_FOUND) |-> (rsp_type_a == 3'd0) && (rsp_type_b == 3'd0), "sleep types set without a hit")

   // A table whose first byte is not D fails at once.
   `ASTS_ASSERT(a_first_sig, req_valid && req_ready && req_first && (req_data_byte != SIG_CHAR_D) |=> rsp_valid && (rsp_status == ST_BAD_SIG), "bad signature not reported")

   // A full output register that is not drained blocks the input.
   `ASTS_ASSERT(a_stall_input, rsp_valid && !rsp_ready |-> !req_ready, "item taken while result stalled")

   // Reset empties the output register.
   `ASTS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind aml_sleep_type_scanner asts_checker u_asts_checker (.*);

`default_nettype wire

[test/sleep_scan_checker.sv]
`timescale 1ns / 100ps
// Checker for the sleep type scanner: watches the req, rsp and csr channels and predicts
// one status per table from the table bytes. Depends on asts_pkg.
module sleep_scan_checker import asts_pkg::*; #(
   parameter int MAX_TABLE_BYTES = MAX_TABLE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_status,
   input  logic [2:0] rsp_type_a,
   input  logic [2:0] rsp_type_b,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [5:0] csr_sleep_digit,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] type_a;
      logic [2:0] type_b;
   } scan_verdict_type;

   // "DSDT", byte zero in the low bits.
   localparam logic [31:0] SIGNATURE = {SIG_CHAR_T, SIG_CHAR_D, SIG_CHAR_S, SIG_CHAR_D};

   logic [7:0]       window [16];
   int unsigned      bytes_seen;
   int unsigned      declared_length;
   bit               length_too_big;
   bit               table_closed;
   logic [5:0]       digit_sought;
   scan_verdict_type verdict_queue [$];
   int               mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [7:0] table_byte(input int unsigned pos);
      return window[pos % 16];
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < 16; i++) window[i] = '0;
      bytes_seen      = 0;
      declared_length = 0;
      length_too_big  = 1'b0;
   endfunction

   // Tests start position p for the _Sx_ package and returns the two sleep types on a hit.
   function automatic bit match_package(input int unsigned p, output logic [2:0] ta,
                                        output logic [2:0] tb);
      int unsigned off;
      logic [7:0]  lead;
      logic [7:0]  value_a;
      logic [7:0]  value_b;
      ta = '0;
      tb = '0;
      if (table_byte(p) != UNDERSCORE || table_byte(p + 1) != CHAR_S ||
          table_byte(p + 2) != {2'b00, digit_sought} || table_byte(p + 3) != UNDERSCORE)
         return 1'b0;
      if (!(table_byte(p - 1) == NAME_OP ||
            (table_byte(p - 2) == NAME_OP && table_byte(p - 1) == ROOT_CHAR)))
         return 1'b0;
      if (table_byte(p + 4) != PACKAGE_OP)
         return 1'b0;
      lead = table_byte(p + 5);
      off  = 7 + lead[7:6];
      if (p + off >= declared_length) return 1'b0;
      if (table_byte(p + off) == BYTE_PREFIX) off++;
      if (p + off >= declared_length) return 1'b0;
      value_a = table_byte(p + off);
      off++;
      if (p + off >= declared_length) return 1'b0;
      if (table_byte(p + off) == BYTE_PREFIX) off++;
      if (p + off >= declared_length) return 1'b0;
      value_b = table_byte(p + off);
      ta = value_a[2:0];
      tb = value_b[2:0];
      return 1'b1;
   endfunction

   task automatic predict_byte(input logic [7:0] b, input bit first, input bit last);
      int unsigned       pos;
      int unsigned       p;
      longint unsigned   sum;
      bit                decided_now;
      logic [2:0]        status;
      logic [2:0]        ta;
      logic [2:0]        tb;
      scan_verdict_type  verdict;
      decided_now = 1'b0;
      status      = ST_NOT_FOUND;
      ta          = '0;
      tb          = '0;
      if (first) begin
         clear_table();
         table_closed = 1'b0;
      end
      if (table_closed) return;

      pos = bytes_seen;
      window[pos % 16] = b;
      bytes_seen = pos + 1;

      if (pos < 4) begin
         if (b != SIGNATURE[8 * pos +: 8]) begin
            decided_now = 1'b1;
            status      = ST_BAD_SIG;
         end
      end else if (pos < 8) begin
         if (!length_too_big) begin
            sum = 64'(declared_length) + (64'(b) << (8 * (pos - 4)));
            if (sum > MAX_TABLE_BYTES) length_too_big = 1'b1;
            else declared_length = int'(sum);
         end
         if (pos == 7 && (length_too_big || declared_length < HDR_MIN_LEN)) begin
            decided_now = 1'b1;
            status      = ST_BAD_LEN;
         end
      end else begin
         // The position thirteen bytes before the newest one now has its whole pattern in the window.
         if (bytes_seen >= SCAN_START + 14) begin
            p = bytes_seen - 14;
            if (p + 8 < declared_length) begin
               if (match_package(p, ta, tb)) begin
                  decided_now = 1'b1;
                  status      = ST_FOUND;
               end
            end
         end
         // At the end of the table the positions not yet tested are swept in order.
         if (!decided_now && bytes_seen >= declared_length) begin
            p = (declared_length - 13 > SCAN_START) ? declared_length - 13 : SCAN_START;
            while (!decided_now && p + 8 < declared_length) begin
               if (match_package(p, ta, tb)) begin
                  decided_now = 1'b1;
                  status      = ST_FOUND;
               end
               p++;
            end
            if (!decided_now) begin
               decided_now = 1'b1;
               status      = ST_NOT_FOUND;
            end
         end
      end

      if (!decided_now && last) begin
         decided_now = 1'b1;
         status      = ST_TRUNC;
      end
      if (decided_now) begin
         table_closed = 1'b1;
         if (status != ST_FOUND) begin
            ta = '0;
            tb = '0;
         end
         verdict.status = status;
         verdict.type_a = ta;
         verdict.type_b = tb;
         verdict_queue.push_back(verdict);
      end
   endtask

   always @(posedge clock) begin : monitor
      scan_verdict_type want;
      bit               bad;
      if (reset) begin
         clear_table();
         table_closed = 1'b1;
         digit_sought = DIGIT_RESET;
         verdict_queue.delete();
      end else begin
         if (csr_valid && csr_ready) digit_sought = csr_sleep_digit;
         if (req_valid && req_ready) predict_byte(req_data_byte, req_first, req_last);
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, status %0d type_a %0d type_b %0d",
                        $time, rsp_status, rsp_type_a, rsp_type_b);
            end else begin
               want = verdict_queue.pop_front();
               bad  = 1'b0;
               if (rsp_status != want.status) begin
                  bad = 1'b1;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_type_a != want.type_a) begin
                  bad = 1'b1;
                  $display("%0t: type_a expected %0d, got %0d",
                           $time, want.type_a, rsp_type_a);
               end
               if (rsp_type_b != want.type_b) begin
                  bad = 1'b1;
                  $display("%0t: type_b expected %0d, got %0d",
                           $time, want.type_b, rsp_type_b);
               end
               if (bad) mismatches++;
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= verdict_queue.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Top of the sleep type scanner testbench: clock, reset, table stimulus and the verdict.
// Depends on asts_pkg, aml_sleep_type_scanner and sleep_scan_checker.
module tb_top;
   import asts_pkg::*;

   localparam int MAX_BYTES = MAX_TABLE_BYTES_DEF;

   // Sleep digits used by the random phases, first phase in the low bits. They include both
   // ends of the ASCII digit range, a value outside it, and finally the reset value again.
   localparam logic [35:0] DIGIT_PLAN = {6'd53, 6'd54, 6'd51, 6'd10, 6'd57, 6'd48};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = '0;
   logic       req_first = 1'b0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [2:0] rsp_type_a;
   logic [2:0] rsp_type_b;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_sleep_digit = '0;

   int fail_count;
   int pending_count;

   // Idle percentages of the current phase, and the digit the tables are built for.
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   logic [5:0] digit_now = DIGIT_RESET;
   int         items_sent = 0;

   // Byte image of the table being sent; only the bytes actually sent are built.
   logic [7:0] image [0:1023];
   int         image_len;

   always #5 clock = ~clock;

   aml_sleep_type_scanner #(.MAX_TABLE_BYTES(MAX_BYTES)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_first(req_first),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_type_a(rsp_type_a),
      .rsp_type_b(rsp_type_b),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_sleep_digit(csr_sleep_digit)
   );

   sleep_scan_checker #(.MAX_TABLE_BYTES(MAX_BYTES)) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_first(req_first),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_type_a(rsp_type_a),
      .rsp_type_b(rsp_type_b),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_sleep_digit(csr_sleep_digit),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // The receiver decides afresh every cycle whether to stall, so stalls land on every
   // phase of the scan.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Offers one item and returns at the edge where it is accepted. Valid stays high after
   // acceptance, so the caller either offers the next item right away or lowers it.
   task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_first     <= first;
      req_last      <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Holds the sender off until every expected result has been taken. The first edge lets
   // the checker count the item accepted at the current edge.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // The digit register is only written with no table open and no result outstanding.
   // The extra cycles cover a table that is still being swept after its last byte.
   task automatic write_digit(input logic [5:0] d);
      settle();
      repeat (20) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_sleep_digit <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      digit_now = d;
   endtask

   function automatic void place(input int pos, input logic [7:0] v);
      if (pos < image_len) image[pos] = v;
   endfunction

   // Builds and sends one table. Most tables are well formed, with zero to three package
   // patterns in the body; the rest are cut short, dropped by a restart, or carry a bad
   // signature or a bad length.
   task automatic send_table();
      int          kind;
      int          n;
      int          limit;
      int          hi;
      int          lo;
      int          p;
      int          k;
      int          bad_sig_at;
      bit          last_flag;
      logic [31:0] length_field;
      logic [7:0]  lead;
      kind         = $urandom_range(99);
      length_field = ($urandom_range(9) == 0) ? $urandom_range(91, 400)
                                               : $urandom_range(HDR_MIN_LEN, 90);
      if ($urandom_range(19) == 0) length_field = HDR_MIN_LEN;
      n          = int'(length_field);
      last_flag  = 1'($urandom_range(1));
      bad_sig_at = 0;
      if (kind < 60) begin
         // Complete table, sometimes followed by bytes the block must ignore.
         if ($urandom_range(9) == 0) n = n + $urandom_range(1, 8);
      end else if (kind < 78) begin
         // Cut short: with last set it is truncated, without it the next table restarts.
         n         = $urandom_range(1, n - 1);
         last_flag = (kind < 70);
      end else if (kind < 86) begin
         bad_sig_at = $urandom_range(3);
         n          = $urandom_range(bad_sig_at + 1, 12);
      end else if (kind < 94) begin
         case ($urandom_range(2))
            0:       length_field = $urandom_range(0, HDR_MIN_LEN - 1);
            1:       length_field = MAX_BYTES + 1;
            default: length_field = $urandom;
         endcase
         n = $urandom_range(5, 12);
      end else begin
         // Largest legal length: only a prefix is sent, so it ends truncated or on a hit.
         length_field = MAX_BYTES;
         n            = $urandom_range(40, 120);
         last_flag    = 1'b1;
      end
      image_len = n;

      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       image[i] = NAME_OP;
            1:       image[i] = UNDERSCORE;
            2:       image[i] = PACKAGE_OP;
            3:       image[i] = BYTE_PREFIX;
            default: image[i] = 8'($urandom_range(255));
         endcase
      end
      place(0, SIG_CHAR_D);
      place(1, SIG_CHAR_S);
      place(2, SIG_CHAR_D);
      place(3, SIG_CHAR_T);
      for (int i = 0; i < 4; i++) place(4 + i, length_field[8 * i +: 8]);
      if (kind >= 78 && kind < 86)
         image[bad_sig_at] = image[bad_sig_at] ^ 8'($urandom_range(1, 255));

      // Patterns go anywhere in the scanned range, often near its end, where the reads of
      // the two values run into the table length.
      limit = (length_field < n) ? int'(length_field) : n;
      hi    = (limit - 9 > SCAN_START) ? limit - 9 : SCAN_START;
      lo    = (hi - 5 > SCAN_START) ? hi - 5 : SCAN_START;
      repeat ($urandom_range(3)) begin
         p = $urandom_range(1) ? $urandom_range(SCAN_START, hi) : $urandom_range(lo, hi);
         case ($urandom_range(3))
            0: place(p - 1, NAME_OP);
            1: begin
               place(p - 2, NAME_OP);
               place(p - 1, ROOT_CHAR);
            end
            2: place(p - 1, ROOT_CHAR);
            default: place(p - 1, NAME_OP);
         endcase
         place(p, UNDERSCORE);
         place(p + 1, CHAR_S);
         place(p + 2, ($urandom_range(4) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                                : {2'b00, digit_now});
         place(p + 3, UNDERSCORE);
         place(p + 4, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : PACKAGE_OP);
         lead = 8'($urandom_range(255));
         place(p + 5, lead);
         // Follow bytes and the element count keep their random content.
         k = p + 7 + lead[7:6];
         if ($urandom_range(1)) begin
            place(k, BYTE_PREFIX);
            k++;
         end
         place(k, 8'($urandom_range(255)));
         k++;
         if ($urandom_range(1)) begin
            place(k, BYTE_PREFIX);
            k++;
         end
         place(k, 8'($urandom_range(255)));
      end

      for (int i = 0; i < n; i++) send_byte(image[i], i == 0, last_flag && i == n - 1);
   endtask

   // Safety net against a hang anywhere in the run.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase_start;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the sleep digit still at its reset value.
      // An item without first while no table is open is ignored.
      send_byte(SIG_CHAR_D, 1'b0, 1'b1);
      // Bad signature on byte zero, with an all-ones byte.
      send_byte(8'hFF, 1'b1, 1'b0);
      // Bad signature on the last signature byte, with an all-zero byte.
      send_byte(SIG_CHAR_D, 1'b1, 1'b0);
      send_byte(SIG_CHAR_S, 1'b0, 1'b0);
      send_byte(SIG_CHAR_D, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      // Truncated on the very first byte.
      send_byte(SIG_CHAR_D, 1'b1, 1'b1);
      // A table dropped by a restart, then a length one below the minimum.
      send_byte(SIG_CHAR_D, 1'b1, 1'b0);
      send_byte(SIG_CHAR_S, 1'b0, 1'b0);
      send_byte(SIG_CHAR_D, 1'b1, 1'b0);
      send_byte(SIG_CHAR_S, 1'b0, 1'b0);
      send_byte(SIG_CHAR_D, 1'b0, 1'b0);
      send_byte(SIG_CHAR_T, 1'b0, 1'b0);
      send_byte(8'(HDR_MIN_LEN - 1), 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      // Length far above the maximum, which overflows on the third length byte.
      send_byte(SIG_CHAR_D, 1'b1, 1'b0);
      send_byte(SIG_CHAR_S, 1'b0, 1'b0);
      send_byte(SIG_CHAR_D, 1'b0, 1'b0);
      send_byte(SIG_CHAR_T, 1'b0, 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0, 1'b0);

      // Random phases: no idling, sender idle, receiver stalling, both. Each phase starts
      // with a new sleep digit and ends on an item that always closes the table.
      for (int phase = 0; phase < 6; phase++) begin
         write_digit(DIGIT_PLAN[6 * phase +: 6]);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 64;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 64;
            end
            default: begin
               sender_idle_pct    = 34;
               receiver_stall_pct = 34;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < 220) begin
            // A stray item between tables, taken into a table cut short without last, else ignored.
            if ($urandom_range(9) == 0)
               send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            send_table();
            // Now and then the sender holds off until every result is in.
            if ($urandom_range(7) == 0) settle();
         end
         send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
